>>> sv/stpb_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Telemetry packet builder package
// Shared widths, codes, command type and byte-level helpers for the
// front end, command queue and back end of the packet builder.
// ---------------------------------------------------------------------------
package stpb_pkg;

  // Configuration register indexes
  localparam logic [1:0] CfgOwnApid    = 2'd0;
  localparam logic [1:0] CfgMaxDataLen = 2'd1;
  localparam logic [1:0] CfgBufCap     = 2'd2;

  // Configuration reset values
  localparam logic [10:0] OwnApidReset    = 11'd0;
  localparam logic [7:0]  MaxDataLenReset = 8'd213;
  localparam logic [7:0]  BufCapReset     = 8'd255;

  // Input operation codes
  localparam logic OpStart = 1'b0;
  localparam logic OpData  = 1'b1;

  // Packet framing constants
  localparam int unsigned HdrBytes     = 14;
  localparam logic [8:0]  NonDataBytes = 9'd16;
  localparam logic [15:0] PlenOffset   = 16'd9;
  localparam logic [13:0] SeqMax       = 14'd16383;
  localparam logic [13:0] ForeignSeq   = 14'd255;
  localparam logic [15:0] CrcInit      = 16'hFFFF;
  localparam logic [15:0] CrcPoly      = 16'h1021;
  localparam logic [7:0]  VersionBits  = 8'h08;
  localparam logic [7:0]  SeqFlagBits  = 8'hC0;
  localparam logic [7:0]  PusVersion   = 8'h10;

  // Command queue depth
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Back-end byte positions
  localparam logic [3:0] HdrFirstIdx = 4'd0;
  localparam logic [3:0] HdrLastIdx  = 4'd13;
  localparam logic [3:0] HdrCrcHiIdx = 4'd14;
  localparam logic [3:0] HdrCrcLoIdx = 4'd15;
  localparam logic [3:0] DatByteIdx  = 4'd0;
  localparam logic [3:0] DatCrcHiIdx = 4'd1;
  localparam logic [3:0] DatCrcLoIdx = 4'd2;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StTooMuch  = 2'd1,
    StBufSmall = 2'd2,
    StNoPacket = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CmdErr  = 2'd0,
    CmdHdr  = 2'd1,
    CmdData = 2'd2
  } cmd_kind_e;

  // One classified item handed from front to back
  typedef struct packed {
    cmd_kind_e   kind;
    status_e     status;
    logic [10:0] apid;
    logic [13:0] seq;
    logic [7:0]  stype;
    logic [7:0]  ssub;
    logic [31:0] ctime;
    logic [7:0]  len;
    logic [7:0]  dbyte;
    logic        last;
  } cmd_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // CRC-16-CCITT over one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  // Header byte at position idx of a start command
  function automatic logic [7:0] hdr_byte(input cmd_t cmd, input logic [3:0] idx);
    logic [15:0] plen;
    logic [7:0]  b;
    plen = {8'h00, cmd.len} + PlenOffset;
    case (idx)
      4'd0:    b = VersionBits | {5'b0, cmd.apid[10:8]};
      4'd1:    b = cmd.apid[7:0];
      4'd2:    b = SeqFlagBits | {2'b0, cmd.seq[13:8]};
      4'd3:    b = cmd.seq[7:0];
      4'd4:    b = plen[15:8];
      4'd5:    b = plen[7:0];
      4'd6:    b = PusVersion;
      4'd7:    b = cmd.stype;
      4'd8:    b = cmd.ssub;
      4'd9:    b = cmd.ctime[31:24];
      4'd10:   b = cmd.ctime[23:16];
      4'd11:   b = cmd.ctime[15:8];
      4'd12:   b = cmd.ctime[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> sv/stpb_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Packet builder front end
// Holds configuration, sequence counter and open-packet tracking; checks
// each transfer and pushes one classified command into the queue.
// ---------------------------------------------------------------------------
module stpb_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [10:0]           cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  operation_i,
  input  logic [10:0]           apid_i,
  input  logic [7:0]            service_type_i,
  input  logic [7:0]            service_subtype_i,
  input  logic [31:0]           coarse_time_i,
  input  logic [7:0]            data_length_i,
  input  logic [7:0]            data_byte_i,
  input  stpb_pkg::queue_stat_t q_stat_i,
  output logic                  q_push_o,
  output stpb_pkg::cmd_t        q_cmd_o
);

  logic [10:0] own_apid_q, own_apid_d;
  logic [7:0]  max_len_q, max_len_d;
  logic [7:0]  buf_cap_q, buf_cap_d;
  logic [13:0] seq_q, seq_d;
  logic [7:0]  rem_q, rem_d;
  logic        open_q, open_d;
  logic        accept;
  logic [8:0]  need;
  logic [13:0] seq_next;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;
  assign q_push_o   = accept;
  assign need       = {1'b0, data_length_i} + stpb_pkg::NonDataBytes;
  assign seq_next   = (seq_q >= stpb_pkg::SeqMax) ? 14'd0 : seq_q + 14'd1;

  // Decode configuration writes
  always_comb begin
    own_apid_d = own_apid_q;
    max_len_d  = max_len_q;
    buf_cap_d  = buf_cap_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        stpb_pkg::CfgOwnApid:    own_apid_d = cfg_data_i;
        stpb_pkg::CfgMaxDataLen: max_len_d  = cfg_data_i[7:0];
        stpb_pkg::CfgBufCap:     buf_cap_d  = cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Classify the transfer and advance packet state
  always_comb begin
    seq_d   = seq_q;
    rem_d   = rem_q;
    open_d  = open_q;
    q_cmd_o = '{
      kind:   stpb_pkg::CmdErr,
      status: stpb_pkg::StOk,
      apid:   apid_i,
      seq:    stpb_pkg::ForeignSeq,
      stype:  service_type_i,
      ssub:   service_subtype_i,
      ctime:  coarse_time_i,
      len:    data_length_i,
      dbyte:  data_byte_i,
      last:   1'b0
    };
    if (operation_i == stpb_pkg::OpStart) begin
      open_d = 1'b0;
      rem_d  = 8'd0;
      if (data_length_i > max_len_q) begin
        q_cmd_o.status = stpb_pkg::StTooMuch;
      end else if ({1'b0, buf_cap_q} < need) begin
        q_cmd_o.status = stpb_pkg::StBufSmall;
      end else begin
        q_cmd_o.kind = stpb_pkg::CmdHdr;
        q_cmd_o.last = (data_length_i == 8'd0);
        if (apid_i == own_apid_q) begin
          seq_d       = seq_next;
          q_cmd_o.seq = seq_next;
        end
        open_d = (data_length_i != 8'd0);
        rem_d  = data_length_i;
      end
    end else if (!open_q) begin
      q_cmd_o.status = stpb_pkg::StNoPacket;
    end else begin
      q_cmd_o.kind = stpb_pkg::CmdData;
      q_cmd_o.last = (rem_q == 8'd1);
      rem_d        = rem_q - 8'd1;
      open_d       = (rem_q != 8'd1);
    end
  end

  // Hold configuration and packet state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_apid_q <= stpb_pkg::OwnApidReset;
      max_len_q  <= stpb_pkg::MaxDataLenReset;
      buf_cap_q  <= stpb_pkg::BufCapReset;
      seq_q      <= 14'd0;
      rem_q      <= 8'd0;
      open_q     <= 1'b0;
    end else begin
      own_apid_q <= own_apid_d;
      max_len_q  <= max_len_d;
      buf_cap_q  <= buf_cap_d;
      if (accept) begin
        seq_q  <= seq_d;
        rem_q  <= rem_d;
        open_q <= open_d;
      end
    end
  end

`ifndef SYNTHESIS
  // An open packet always has bytes left to come
  assert property (@(posedge clk_i) disable iff (!rst_ni) open_q |-> rem_q != 8'd0)
    else $error("open packet with zero bytes remaining");
  // The counter moves only on an accepted start of the own APID
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(accept && operation_i == stpb_pkg::OpStart) |=> $stable(seq_q))
    else $error("sequence counter moved without a start");
`endif

endmodule

>>> sv/stpb_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Packet builder command queue
// Short FIFO of classified commands between front end and back end.
// ---------------------------------------------------------------------------
module stpb_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  stpb_pkg::cmd_t        cmd_i,
  input  logic                  pop_i,
  output stpb_pkg::cmd_t        head_o,
  output stpb_pkg::queue_stat_t stat_o
);

  stpb_pkg::cmd_t                      entries_q [stpb_pkg::QueueDepth];
  logic [stpb_pkg::QueuePtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [stpb_pkg::QueueCntW-1:0]      count_q;

  localparam logic [stpb_pkg::QueueCntW-1:0] Depth =
    stpb_pkg::QueueCntW'(stpb_pkg::QueueDepth);
  localparam logic [stpb_pkg::QueuePtrW-1:0] LastPtr =
    stpb_pkg::QueuePtrW'(stpb_pkg::QueueDepth - 1);

  assign head_o       = entries_q[rd_ptr_q];
  assign stat_o.full  = (count_q == Depth);
  assign stat_o.empty = (count_q == '0);

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !stat_o.full)
    else $error("push into full command queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !stat_o.empty)
    else $error("pop from empty command queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= Depth)
    else $error("command queue count overflow");
`endif

endmodule

>>> sv/stpb_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Packet builder back end
// Expands queued commands into output bytes one per cycle unless stalled,
// runs the packet CRC and drives the registered output channel.
// ---------------------------------------------------------------------------
module stpb_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  stpb_pkg::cmd_t        head_i,
  input  stpb_pkg::queue_stat_t q_stat_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            out_byte_o,
  output logic                  packet_end_o,
  output logic [1:0]            status_o
);

  logic [3:0]  cnt_q, cnt_d;
  logic [15:0] crc_q, crc_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, byte_d;
  logic        out_end_q, end_d;
  logic [1:0]  out_status_q, status_d;
  logic        adv, fire, done;
  logic [7:0]  hbyte;

  assign adv   = !out_valid_q || !out_stall_i;
  assign fire  = adv && !q_stat_i.empty;
  assign pop_o = fire && done;
  assign hbyte = stpb_pkg::hdr_byte(head_i, cnt_q);

  // Select the byte at the current position of the head command
  always_comb begin
    byte_d   = 8'h00;
    end_d    = 1'b0;
    status_d = stpb_pkg::StOk;
    crc_d    = crc_q;
    done     = 1'b0;
    case (head_i.kind)
      stpb_pkg::CmdHdr: begin
        if (cnt_q == stpb_pkg::HdrCrcHiIdx) begin
          byte_d = crc_q[15:8];
        end else if (cnt_q == stpb_pkg::HdrCrcLoIdx) begin
          byte_d = crc_q[7:0];
          end_d  = 1'b1;
          crc_d  = stpb_pkg::CrcInit;
          done   = 1'b1;
        end else begin
          byte_d = hbyte;
          crc_d  = stpb_pkg::crc_byte(
                     (cnt_q == stpb_pkg::HdrFirstIdx) ? stpb_pkg::CrcInit : crc_q, hbyte);
          done   = (cnt_q == stpb_pkg::HdrLastIdx) && !head_i.last;
        end
      end
      stpb_pkg::CmdData: begin
        if (cnt_q == stpb_pkg::DatByteIdx) begin
          byte_d = head_i.dbyte;
          crc_d  = stpb_pkg::crc_byte(crc_q, head_i.dbyte);
          done   = !head_i.last;
        end else if (cnt_q == stpb_pkg::DatCrcHiIdx) begin
          byte_d = crc_q[15:8];
        end else begin
          byte_d = crc_q[7:0];
          end_d  = 1'b1;
          crc_d  = stpb_pkg::CrcInit;
          done   = 1'b1;
        end
      end
      default: begin
        end_d    = 1'b1;
        status_d = head_i.status;
        done     = 1'b1;
      end
    endcase
  end

  // Step through positions and load the output register
  always_comb begin
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
      cnt_d       = done ? 4'd0 : cnt_q + 4'd1;
    end else if (adv) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= 4'd0;
      crc_q       <= stpb_pkg::CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        crc_q <= crc_d;
      end
    end
  end

  // Output payload, held while stalled
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_byte_q   <= byte_d;
      out_end_q    <= end_d;
      out_status_q <= status_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign packet_end_o = out_end_q;
  assign status_o     = out_status_q;

`ifndef SYNTHESIS
  // Error results are single zero bytes closing the packet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q != stpb_pkg::StOk |-> out_end_q && out_byte_q == 8'h00)
    else $error("malformed error result");
  // A finished command restarts the position counter
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_o |=> cnt_q == 4'd0)
    else $error("position counter not cleared after command");
  // The position never runs past the CRC low byte of a data command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_stat_i.empty && head_i.kind == stpb_pkg::CmdData |-> cnt_q <= stpb_pkg::DatCrcLoIdx)
    else $error("data command position out of range");
`endif

endmodule

>>> sv/space_telemetry_packet_builder_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Telemetry packet builder core
// Builds space packets with a PUS telemetry header and a CRC-16-CCITT trailer.
// ---------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): a start transfer carries APID,
// service type/subtype, coarse time and data length; a data transfer carries
// one source byte. Output channel (out_valid_o / out_stall_i) delivers one
// packet byte per transfer with packet_end_o and status_o.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_data_i) are taken at any
// edge and are meant for an idle block.
// The first result of a transfer is written into the command queue and then
// loaded into the output register once the back end reaches it. An accepted
// data byte yields that byte, the last data byte also the two CRC bytes, an
// accepted start the header bytes (and the CRC bytes with zero data length),
// a rejected start or stray byte a single zero result byte. The single
// byte-wide output register paces the output; a four-entry command queue lets
// the input side run ahead of the output side.
// Reset clears the queue, output valid flag, sequence counter and packet state
// and loads the configuration defaults. When the receiver stalls, the output
// holds; input is stalled only once the command queue is full.
// ---------------------------------------------------------------------------
module space_telemetry_packet_builder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [10:0] apid_i,
  input  logic [7:0]  service_type_i,
  input  logic [7:0]  service_subtype_i,
  input  logic [31:0] coarse_time_i,
  input  logic [7:0]  data_length_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        packet_end_o,
  output logic [1:0]  status_o
);

  stpb_pkg::queue_stat_t q_stat;
  stpb_pkg::cmd_t        q_cmd, q_head;
  logic                  q_push, q_pop;

  // Classify incoming transfers
  stpb_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .operation_i       (operation_i),
    .apid_i            (apid_i),
    .service_type_i    (service_type_i),
    .service_subtype_i (service_subtype_i),
    .coarse_time_i     (coarse_time_i),
    .data_length_i     (data_length_i),
    .data_byte_i       (data_byte_i),
    .q_stat_i          (q_stat),
    .q_push_o          (q_push),
    .q_cmd_o           (q_cmd)
  );

  // Buffer commands between the two sides
  stpb_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (q_cmd),
    .pop_i  (q_pop),
    .head_o (q_head),
    .stat_o (q_stat)
  );

  // Emit packet bytes
  stpb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (q_head),
    .q_stat_i     (q_stat),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .packet_end_o (packet_end_o),
    .status_o     (status_o)
  );

endmodule
